// ===== sv/rfsm_pkg.sv =====
// Shared types and codes for the reference frame slot manager.
// Holds the request and result payload structs and the status codes.
// No dependencies.
`timescale 1ns / 1ps

package rfsm_pkg;

    localparam int FRAME_COUNT_W = 16;
    localparam int PERIOD_W      = 16;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_REF_MISS  = 2'd1,
        ST_NO_FREE   = 2'd2
    } t_status;

    localparam logic KIND_REFRESH   = 1'b0;
    localparam logic KIND_PREDICTED = 1'b1;

    typedef struct packed {
        logic [FRAME_COUNT_W-1:0] frame_count;
        logic                     force_refresh;
    } t_in_req;

    typedef struct packed {
        t_status                  status_code;
        logic                     frame_kind;
        logic                     ref_slot;
        logic                     recon_slot;
        logic [FRAME_COUNT_W-1:0] next_count;
    } t_out_req;

endpackage

// ===== sv/ref_frame_slot_manager.sv =====
// Reference frame slot manager: two-slot picture buffer bookkeeping for a P-only encoder.
// One request in flight at a time; the input stalls until the result is registered.
// Each request takes a load step, the 16 steps of the shared restoring subtractor that
// forms frame_count modulo the intra period, and an update step a stalled output can hold.
// Reset (synchronous, active low) clears all slots and sets the intra period to 32.
// Depends on rfsm_pkg.
`timescale 1ns / 1ps

module ref_frame_slot_manager
    import rfsm_pkg::*;
#(
    parameter int SLOTS      = 2,
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_req             i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_req            o_out
);

    localparam int BIT_W = $clog2(FRAME_COUNT_W);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                   r_state, n_state;
    logic [PERIOD_W-1:0]      r_period;
    logic [PERIOD_W-1:0]      r_per;
    logic [COUNT_BITS-1:0]    r_cnt;
    logic                     r_force;
    logic [FRAME_COUNT_W-1:0] r_dvd;
    logic [PERIOD_W-1:0]      r_rem, n_rem;
    logic [BIT_W-1:0]         r_bit;
    logic [SLOTS-1:0]         r_in_use, n_in_use;
    logic [COUNT_BITS-1:0]    r_slot_cnt [SLOTS];
    logic [COUNT_BITS-1:0]    n_slot_cnt [SLOTS];
    logic                     r_out_valid;
    t_out_req                 r_out, n_out;

    logic                     in_acc;
    logic                     upd_go;
    logic [PERIOD_W:0]        rem_shift;
    logic                     rem_ge;

    logic                     refresh;
    logic [COUNT_BITS-1:0]    prev_cnt;
    logic [COUNT_BITS-1:0]    nxt_cnt;
    logic [SLOTS-1:0]         match;
    logic                     ref_found;
    logic                     ref_idx;
    logic [SLOTS-1:0]         use_free;
    logic                     rec_idx;
    logic                     free_found;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign upd_go      = (r_state == S_UPD) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Shared restoring step: one remainder bit per cycle. A zero period leaves the
    // remainder equal to the count, so a zero remainder still means a zero count.
    assign rem_shift = {r_rem, r_dvd[FRAME_COUNT_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, r_per});
    always_comb begin
        n_rem = rem_ge ? PERIOD_W'(rem_shift - {1'b0, r_per}) : PERIOD_W'(rem_shift);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (r_bit == '0) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (upd_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Slot decision, evaluated once the remainder is complete.
    always_comb begin
        refresh  = (r_rem == '0) || r_force;
        prev_cnt = r_cnt - COUNT_BITS'(1);
        nxt_cnt  = r_cnt + COUNT_BITS'(1);
        for (int i = 0; i < SLOTS; i++) begin
            match[i] = r_in_use[i] && (r_slot_cnt[i] == prev_cnt);
        end
        ref_found = |match;
        ref_idx   = !match[0];

        use_free = refresh ? '0 : r_in_use;
        use_free[r_cnt[0]] = 1'b0;
        free_found = !(&use_free);
        rec_idx    = use_free[0];

        n_in_use = r_in_use;
        for (int i = 0; i < SLOTS; i++) begin
            n_slot_cnt[i] = refresh ? '0 : r_slot_cnt[i];
        end

        n_out.status_code = ST_OK;
        n_out.frame_kind  = refresh ? KIND_REFRESH : KIND_PREDICTED;
        n_out.ref_slot    = refresh ? 1'b0 : ref_idx;
        n_out.recon_slot  = 1'b0;
        n_out.next_count  = '0;

        if (!refresh && !ref_found) begin
            n_out.status_code = ST_REF_MISS;
            n_out.ref_slot    = 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                n_slot_cnt[i] = r_slot_cnt[i];
            end
        end else if (!free_found) begin
            n_out.status_code = ST_NO_FREE;
            n_in_use          = use_free;
        end else begin
            n_in_use          = use_free;
            n_in_use[rec_idx] = 1'b1;
            n_slot_cnt[rec_idx] = r_cnt;
            n_out.recon_slot  = rec_idx;
            if (32'(nxt_cnt) == 32'(r_per)) begin
                n_out.next_count = '0;
            end else begin
                n_out.next_count = FRAME_COUNT_W'(nxt_cnt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= PERIOD_W'(32);
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
            r_bit       <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_cnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            if (in_acc) begin
                r_bit <= BIT_W'(FRAME_COUNT_W - 1);
            end else if (r_state == S_DIV) begin
                r_bit <= r_bit - BIT_W'(1);
            end
            if (upd_go) begin
                r_in_use <= n_in_use;
                for (int i = 0; i < SLOTS; i++) begin
                    r_slot_cnt[i] <= n_slot_cnt[i];
                end
            end
            if (upd_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_per   <= r_period;
            r_cnt   <= COUNT_BITS'(i_in.frame_count);
            r_force <= i_in.force_refresh;
            r_dvd   <= FRAME_COUNT_W'(COUNT_BITS'(i_in.frame_count));
            r_rem   <= '0;
        end else if (r_state == S_DIV) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[FRAME_COUNT_W-2:0], 1'b0};
        end
        if (upd_go) begin
            r_out <= n_out;
        end
    end

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_DIV))
        else $error("accepted request did not start the remainder sequence");

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && (r_per != '0)) |-> (r_rem < r_per))
        else $error("partial remainder reached the divisor");

    a_recon_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_go && (n_out.status_code == ST_OK)) |=> r_in_use[$past(rec_idx)])
        else $error("reconstruction slot not marked in use");

    a_result_from_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_UPD))
        else $error("result appeared outside the update step");

endmodule

// ===== tb/sv/ref_frame_slot_manager_checker.sv =====
// Checker for the reference frame slot manager: watches the config, request and result channels.
// Keeps its own copy of the slot table and intra period and compares every result in order.
// Depends on rfsm_pkg.
`timescale 1ns / 1ps

module ref_frame_slot_manager_checker
    import rfsm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  t_in_req             i_in,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  t_out_req            i_out,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int                  NUM_SLOTS    = 2;
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd32;

    logic [PERIOD_W-1:0]      model_period;
    logic                     slot_busy  [NUM_SLOTS];
    logic [FRAME_COUNT_W-1:0] slot_frame [NUM_SLOTS];
    t_out_req                 slot_result_q [$];
    int                       mismatches;

    function automatic void clear_slots();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_busy[i]  = 1'b0;
            slot_frame[i] = '0;
        end
    endfunction

    // Works out the slot assignment for one request and updates the slot table.
    function automatic t_out_req assign_slots(input t_in_req req);
        logic [FRAME_COUNT_W-1:0] cnt;
        logic [FRAME_COUNT_W-1:0] prev;
        logic [FRAME_COUNT_W-1:0] nxt;
        logic                     refresh;
        logic                     hit;
        logic                     ref_idx;
        logic                     rec_idx;
        t_out_req                 res;
        cnt     = req.frame_count;
        res     = '0;
        ref_idx = 1'b0;
        rec_idx = 1'b0;
        hit     = 1'b0;
        if (model_period == '0)
            refresh = (cnt == '0) || req.force_refresh;
        else
            refresh = ((cnt % model_period) == '0) || req.force_refresh;

        if (refresh) begin
            clear_slots();
        end else begin
            prev = cnt - 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!hit && slot_busy[i] && slot_frame[i] == prev) begin
                    ref_idx = i[0];
                    hit     = 1'b1;
                end
            end
            // A missing reference leaves the slot table untouched.
            if (!hit) begin
                res.status_code = ST_REF_MISS;
                res.frame_kind  = KIND_PREDICTED;
                return res;
            end
        end

        slot_busy[cnt[0]] = 1'b0;
        hit = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!hit && !slot_busy[i]) begin
                rec_idx = i[0];
                hit     = 1'b1;
            end
        end
        res.frame_kind = refresh ? KIND_REFRESH : KIND_PREDICTED;
        res.ref_slot   = ref_idx;
        if (!hit) begin
            res.status_code = ST_NO_FREE;
            return res;
        end
        slot_busy[rec_idx]  = 1'b1;
        slot_frame[rec_idx] = cnt;

        nxt = cnt + 1'b1;
        if (nxt == model_period)
            nxt = '0;
        res.status_code = ST_OK;
        res.recon_slot  = rec_idx;
        res.next_count  = nxt;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_req want;
        if (!i_rst_n) begin
            clear_slots();
            model_period = RESET_PERIOD;
            slot_result_q.delete();
        end else begin
            if (i_cfg_we)
                model_period = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (slot_result_q.size() == 0) begin
                    $error("result with no request outstanding: status %0d next_count %0d",
                           i_out.status_code, i_out.next_count);
                    mismatches++;
                end else begin
                    want = slot_result_q.pop_front();
                    check_field("status_code", 16'(want.status_code),
                                16'(i_out.status_code));
                    check_field("frame_kind", 16'(want.frame_kind), 16'(i_out.frame_kind));
                    check_field("ref_slot", 16'(want.ref_slot), 16'(i_out.ref_slot));
                    check_field("recon_slot", 16'(want.recon_slot), 16'(i_out.recon_slot));
                    check_field("next_count", 16'(want.next_count), 16'(i_out.next_count));
                end
            end
            if (i_in_valid && !i_in_stall)
                slot_result_q.push_back(assign_slots(i_in));
        end
        o_pending    <= slot_result_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/sv/ref_frame_slot_manager_tb.sv =====
// Top of the reference frame slot manager testbench: clock, reset, stimulus and verdict.
// Drives frame requests and intra period settings; the checker module does all comparing.
// Depends on rfsm_pkg, ref_frame_slot_manager and ref_frame_slot_manager_checker.
`timescale 1ns / 1ps

module ref_frame_slot_manager_tb;
    import rfsm_pkg::*;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [PERIOD_W-1:0] cfg_data  = '0;
    logic                in_valid  = 1'b0;
    t_in_req             in_req    = '0;
    logic                out_stall = 1'b0;
    logic                in_stall;
    logic                out_valid;
    t_out_req            out_resp;
    int                  fail_count;
    int                  pending;
    int                  cyc         = 0;
    int unsigned         frames_sent = 0;
    logic [PERIOD_W-1:0] period_now  = 16'd32;
    logic                quiet;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) cyc <= cyc + 1;

    // Neither side idles inside this window.
    assign quiet = (cyc >= 8000) && (cyc < 14000);

    ref_frame_slot_manager uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_resp)
    );

    ref_frame_slot_manager_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_resp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_frame(input logic [FRAME_COUNT_W-1:0] count, input logic force_ref);
        t_in_req req;
        req.frame_count   = count;
        req.force_refresh = force_ref;
        if (!quiet) begin
            while ($urandom_range(99) < 9) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_req   <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        frames_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] p);
        cfg_we   <= 1'b1;
        cfg_data <= p;
        @(posedge clk);
        cfg_we     <= 1'b0;
        period_now  = p;
    endtask

    // Mostly runs of consecutive frames that usually start on a forced refresh, with skipped and
    // repeated frames mixed in; the rest are requests with random content.
    task automatic run_random(input int unsigned n_items);
        int unsigned              stop_at;
        int unsigned              pick;
        int unsigned              run_len;
        logic [FRAME_COUNT_W-1:0] cnt;
        logic [FRAME_COUNT_W-1:0] nxt;
        logic                     f;
        stop_at = frames_sent + n_items;
        while (frames_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                case ($urandom_range(3))
                    0:       cnt = '0;
                    1:       cnt = FRAME_COUNT_W'(16'hFFFF - $urandom_range(40));
                    default: cnt = FRAME_COUNT_W'($urandom_range(16'hFFFF));
                endcase
                f       = ($urandom_range(9) < 8);
                run_len = $urandom_range(40, 2);
                if (run_len > stop_at - frames_sent)
                    run_len = stop_at - frames_sent;
                repeat (run_len) begin
                    send_frame(cnt, f);
                    nxt = cnt + 1'b1;
                    if (nxt == period_now)
                        nxt = '0;
                    pick = $urandom_range(99);
                    if (pick < 3)
                        nxt = nxt + 1'b1;
                    else if (pick < 6)
                        nxt = cnt;
                    cnt = nxt;
                    f   = ($urandom_range(99) < 3);
                end
            end else begin
                send_frame(FRAME_COUNT_W'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin : stimulus
        logic [PERIOD_W-1:0] p;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests at the reset intra period.
        send_frame(16'd0, 1'b0);
        send_frame(16'd1, 1'b0);
        send_frame(16'd2, 1'b0);
        send_frame(16'd3, 1'b0);
        send_frame(16'd4, 1'b1);
        send_frame(16'd5, 1'b0);
        send_frame(16'd7, 1'b0);
        send_frame(16'd6, 1'b0);
        send_frame(16'd7, 1'b0);
        send_frame(16'd32, 1'b0);
        send_frame(16'd33, 1'b0);
        send_frame(16'd33, 1'b0);
        send_frame(16'hFFFF, 1'b1);
        send_frame(16'd0, 1'b0);
        send_frame(16'hFFFF, 1'b0);
        send_frame(16'd30, 1'b1);
        send_frame(16'd31, 1'b0);
        send_frame(16'd0, 1'b0);
        send_frame(16'd1, 1'b0);
        send_frame(16'h8000, 1'b0);
        send_frame(16'hAAAA, 1'b1);
        send_frame(16'h5555, 1'b0);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0:       p = 16'd1;
                1:       p = 16'hFFFF;
                2:       p = 16'd0;
                3:       p = 16'd2;
                4:       p = 16'd3;
                6:       p = 16'd7;
                7:       p = 16'd32;
                default: p = PERIOD_W'($urandom_range(16'hFFFF, 4));
            endcase
            write_period(p);
            run_random(160);
            drain();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls, plus long hold-offs that back the block up.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (cyc % 15000 == 3000) begin
                hold_left = 400;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !quiet && ($urandom_range(99) < 9);
            end
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
